// ===== rtl/dts_pkg.sv =====
`timescale 1ns / 1ps
package dts_pkg;

    typedef enum logic [2:0] {
        OP_SCHEDULE = 3'd0,
        OP_HOST     = 3'd1,
        OP_CANCEL   = 3'd2,
        OP_BEGIN    = 3'd3,
        OP_NEXT     = 3'd4,
        OP_DONE     = 3'd5,
        OP_QUERY    = 3'd6,
        OP_NONE     = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        REG_INITIAL_TIME = 3'd0,
        REG_MAX_DELAY    = 3'd1,
        REG_NEST_THRESH  = 3'd2,
        REG_NEST_MIN     = 3'd3,
        REG_HOST_CAP     = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN2,
        S_FINISH,
        S_WRITE
    } state_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [39:0] requested_delay;
        logic               delay_present;
        logic               repeat_flag;
        logic               trust_context;
        logic [31:0]        target_id;
        logic [47:0]        current_time;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] id_out;
        logic        trusted_out;
        logic [31:0] delay_out;
        logic        any_pending;
    } res_t;

    localparam int unsigned ENTRY_W = 32 + 49 + 31 + 3 + 8;
    localparam logic [7:0]  DRAIN_CLOSED = 8'd255;

endpackage

// ===== rtl/dts_ram.sv =====
`timescale 1ns / 1ps
module dts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/deadline_timer_scheduler_unit.sv =====
`timescale 1ns / 1ps
// Timer table with earliest-deadline service. One request runs at a time: busy rises on
// start and a request (schedule, host task, cancel, begin turn, query) takes one
// sweep of the entry memory, or two sweeps for a fetch that falls through to host
// tasks; the length is set by these sweeps of the entry memory, which read one entry per
// cycle through a single compare unit. Each result shows for one cycle with done high
// and cannot be held off. Write configuration only while idle.
module deadline_timer_scheduler_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  dts_pkg::req_t      request,
    output logic               done,
    output dts_pkg::res_t      result,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [47:0]        cfg_data
);
    localparam int AW = $clog2(TABLE_DEPTH);

    logic [30:0] max_delay_reg;
    logic [7:0]  nest_thr_reg;
    logic [15:0] nest_min_reg;
    logic [7:0]  host_cap_reg;

    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [TABLE_DEPTH-1:0] snap_reg, snap_next;
    logic [31:0] id_cnt_reg, id_cnt_next;
    logic [47:0] epoch_reg, epoch_next;
    logic [7:0]  run_nest_reg, run_nest_next;
    logic [7:0]  drained_reg, drained_next;

    dts_pkg::state_t state_reg, state_next;
    dts_pkg::req_t   req_reg, req_next;
    dts_pkg::res_t   res_reg, res_next;
    logic            done_reg, done_next;
    logic [AW:0]     idx_reg, idx_next;
    logic            best_ok_reg, best_ok_next;
    logic [AW-1:0]   best_reg, best_next;
    logic [48:0]     best_due_reg, best_due_next;
    logic [31:0]     best_id_reg, best_id_next;
    logic            free_ok_reg, free_ok_next;
    logic [AW-1:0]   free_reg, free_next;
    logic            any_reg, any_next;

    logic                we;
    logic [AW-1:0]       waddr, raddr;
    logic [dts_pkg::ENTRY_W-1:0] wdata, rdata;

    logic [31:0] e_id;
    logic [48:0] e_due;
    logic [30:0] e_int;
    logic [2:0]  e_flags;
    logic [7:0]  e_nest;

    logic [AW-1:0] cur;
    logic          cur_ok;
    logic          earlier;
    logic [39:0]   d0;
    logic [30:0]   d1;
    logic [30:0]   d2;

    dts_ram #(.WIDTH(dts_pkg::ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    assign {e_id, e_due, e_int, e_flags, e_nest} = rdata;
    assign cur    = idx_reg[AW-1:0] - AW'(1);
    assign cur_ok = (idx_reg != '0);
    assign earlier = !best_ok_reg || (e_due < best_due_reg) ||
                     ((e_due == best_due_reg) && (e_id < best_id_reg));
    assign raddr = (state_reg == dts_pkg::S_FINISH) ? best_reg : idx_reg[AW-1:0];
    assign busy   = (state_reg != dts_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    always_comb
    begin
        d0 = (req_reg.delay_present && !req_reg.requested_delay[39])
             ? 40'(req_reg.requested_delay) : 40'd0;
        d1 = (d0 > 40'(max_delay_reg)) ? max_delay_reg : d0[30:0];
        d2 = ((run_nest_reg > nest_thr_reg) && (d1 < 31'(nest_min_reg)))
             ? 31'(nest_min_reg) : d1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_delay_reg <= 31'h7fffffff;
            nest_thr_reg  <= 8'd5;
            nest_min_reg  <= 16'd4;
            host_cap_reg  <= 8'd64;
            valid_reg     <= '0;
            snap_reg      <= '0;
            id_cnt_reg    <= 32'd1;
            epoch_reg     <= '0;
            run_nest_reg  <= '0;
            drained_reg   <= '0;
            state_reg     <= dts_pkg::S_IDLE;
            done_reg      <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            snap_reg     <= snap_next;
            id_cnt_reg   <= id_cnt_next;
            epoch_reg    <= epoch_next;
            run_nest_reg <= run_nest_next;
            drained_reg  <= drained_next;
            state_reg    <= state_next;
            done_reg     <= done_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    dts_pkg::REG_MAX_DELAY:   max_delay_reg <= cfg_data[30:0];
                    dts_pkg::REG_NEST_THRESH: nest_thr_reg  <= cfg_data[7:0];
                    dts_pkg::REG_NEST_MIN:    nest_min_reg  <= cfg_data[15:0];
                    dts_pkg::REG_HOST_CAP:    host_cap_reg  <= cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        res_reg      <= res_next;
        idx_reg      <= idx_next;
        best_ok_reg  <= best_ok_next;
        best_reg     <= best_next;
        best_due_reg <= best_due_next;
        best_id_reg  <= best_id_next;
        free_ok_reg  <= free_ok_next;
        free_reg     <= free_next;
        any_reg      <= any_next;
    end

    always_comb
    begin
        valid_next    = valid_reg;
        snap_next     = snap_reg;
        id_cnt_next   = id_cnt_reg;
        epoch_next    = epoch_reg;
        run_nest_next = run_nest_reg;
        drained_next  = drained_reg;
        state_next    = state_reg;
        req_next      = req_reg;
        res_next      = res_reg;
        done_next     = 1'b0;
        idx_next      = idx_reg;
        best_ok_next  = best_ok_reg;
        best_next     = best_reg;
        best_due_next = best_due_reg;
        best_id_next  = best_id_reg;
        free_ok_next  = free_ok_reg;
        free_next     = free_reg;
        any_next      = any_reg;
        we            = 1'b0;
        waddr         = best_reg;
        wdata         = rdata;

        case (state_reg)
            dts_pkg::S_IDLE:
            begin
                if (start)
                begin
                    req_next     = request;
                    idx_next     = '0;
                    best_ok_next = 1'b0;
                    free_ok_next = 1'b0;
                    any_next     = 1'b0;
                    state_next   = dts_pkg::S_SCAN;
                end
            end
            dts_pkg::S_SCAN, dts_pkg::S_SCAN2:
            begin
                idx_next = idx_reg + 1'b1;
                if (cur_ok)
                begin
                    if (!valid_reg[cur] && !free_ok_reg)
                    begin
                        free_ok_next = 1'b1;
                        free_next    = cur;
                    end
                    if (valid_reg[cur])
                    begin
                        case (dts_pkg::op_t'(req_reg.operation))
                            dts_pkg::OP_CANCEL:
                            begin
                                if (e_id == req_reg.target_id)
                                begin
                                    valid_next[cur] = 1'b0;
                                    snap_next[cur]  = 1'b0;
                                end
                            end
                            dts_pkg::OP_BEGIN:
                            begin
                                snap_next[cur] = (e_due <= 49'(req_reg.current_time));
                                if (e_due <= 49'(req_reg.current_time))
                                begin
                                    any_next = 1'b1;
                                end
                            end
                            dts_pkg::OP_NEXT:
                            begin
                                if (((state_reg == dts_pkg::S_SCAN) && snap_reg[cur]) ||
                                    ((state_reg == dts_pkg::S_SCAN2) && e_flags[1] &&
                                     (e_due <= 49'(epoch_reg))))
                                begin
                                    if (earlier)
                                    begin
                                        best_ok_next  = 1'b1;
                                        best_next     = cur;
                                        best_due_next = e_due;
                                        best_id_next  = e_id;
                                    end
                                end
                            end
                            dts_pkg::OP_QUERY:
                            begin
                                if (!best_ok_reg || (e_due < best_due_reg))
                                begin
                                    best_ok_next  = 1'b1;
                                    best_due_next = e_due;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                if (idx_reg == (AW+1)'(TABLE_DEPTH))
                begin
                    if ((state_reg == dts_pkg::S_SCAN) &&
                        (dts_pkg::op_t'(req_reg.operation) == dts_pkg::OP_NEXT) &&
                        !best_ok_next && (drained_reg < host_cap_reg))
                    begin
                        idx_next   = '0;
                        state_next = dts_pkg::S_SCAN2;
                    end
                    else
                    begin
                        state_next = dts_pkg::S_FINISH;
                    end
                end
            end
            dts_pkg::S_FINISH:
            begin
                res_next   = '0;
                state_next = dts_pkg::S_WRITE;
                case (dts_pkg::op_t'(req_reg.operation))
                    dts_pkg::OP_SCHEDULE, dts_pkg::OP_HOST:
                    begin
                        if (!free_ok_reg)
                        begin
                            res_next.status = dts_pkg::ST_FULL;
                        end
                        else
                        begin
                            we    = 1'b1;
                            waddr = free_reg;
                            if (req_reg.operation == dts_pkg::OP_HOST)
                            begin
                                wdata = {id_cnt_reg, 1'b0, epoch_reg, 31'd0,
                                         req_reg.trust_context, 2'b10, 8'd0};
                            end
                            else
                            begin
                                wdata = {id_cnt_reg, 49'(epoch_reg) + 49'(d2),
                                         req_reg.repeat_flag ?
                                         ((d2 == '0) ? 31'd1 : d2) : 31'd0,
                                         req_reg.trust_context, 1'b0,
                                         req_reg.repeat_flag,
                                         (run_nest_reg == 8'd255) ? 8'd255
                                         : run_nest_reg + 8'd1};
                            end
                            valid_next[free_reg] = 1'b1;
                            snap_next[free_reg]  = 1'b0;
                            res_next.id_out      = id_cnt_reg;
                            id_cnt_next          = id_cnt_reg + 32'd1;
                        end
                    end
                    dts_pkg::OP_BEGIN:
                    begin
                        epoch_next   = req_reg.current_time;
                        drained_next = any_reg ? 8'd0 : dts_pkg::DRAIN_CLOSED;
                    end
                    dts_pkg::OP_NEXT:
                    begin
                        if (!best_ok_reg)
                        begin
                            res_next.status = dts_pkg::ST_NONE;
                        end
                    end
                    dts_pkg::OP_DONE:
                    begin
                        run_nest_next = '0;
                    end
                    dts_pkg::OP_QUERY:
                    begin
                        if (best_ok_reg && (best_due_reg > 49'(req_reg.current_time)))
                        begin
                            res_next.delay_out =
                                ((best_due_reg - 49'(req_reg.current_time)) > 49'hffffffff)
                                ? 32'hffffffff
                                : 32'(best_due_reg - 49'(req_reg.current_time));
                        end
                    end
                    default: ;
                endcase
            end
            dts_pkg::S_WRITE:
            begin
                if ((dts_pkg::op_t'(req_reg.operation) == dts_pkg::OP_NEXT) && best_ok_reg)
                begin
                    res_next.id_out      = e_id;
                    res_next.trusted_out = e_flags[2];
                    snap_next[best_reg]  = 1'b0;
                    if (state_reg == dts_pkg::S_WRITE && !snap_reg[best_reg] &&
                        e_flags[1])
                    begin
                        drained_next = drained_reg + 8'd1;
                    end
                    if (e_flags[0])
                    begin
                        we    = 1'b1;
                        waddr = best_reg;
                        wdata = {e_id, 49'(epoch_reg) + 49'(e_int), e_int, e_flags,
                                 (e_nest == 8'd255) ? 8'd255 : e_nest + 8'd1};
                    end
                    else
                    begin
                        valid_next[best_reg] = 1'b0;
                    end
                    run_nest_next = e_flags[1] ? 8'd0 : e_nest;
                end
                res_next.any_pending = |valid_next;
                done_next  = 1'b1;
                state_next = dts_pkg::S_IDLE;
            end
            default:
            begin
                state_next = dts_pkg::S_IDLE;
            end
        endcase

        if (cfg_we && (cfg_index == dts_pkg::REG_INITIAL_TIME))
        begin
            epoch_next = cfg_data;
        end
    end
endmodule

// ===== rtl/dts_checker.sv =====
`timescale 1ns / 1ps
module dts_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input dts_pkg::res_t result
);
    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result while still busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("request not taken");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result repeated");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result.status == dts_pkg::ST_DONE) ||
                  (result.status == dts_pkg::ST_FULL) ||
                  (result.status == dts_pkg::ST_NONE))) else $error("bad status");
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done) else $error("request ended without result");
endmodule

bind deadline_timer_scheduler_unit dts_checker u_dts_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .result(result)
);
